[src/srpf_pkg.sv]
package srpf_pkg;

   // Stream characters the parser reacts to
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_NL    = 8'h0a;
   localparam logic [7:0] CHAR_VT    = 8'h0b;
   localparam logic [7:0] CHAR_FF    = 8'h0c;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_AT    = 8'h40;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UZ    = 8'h5a;
   localparam logic [7:0] CHAR_UL    = 8'h4c;
   localparam logic [7:0] CHAR_UN    = 8'h4e;
   localparam logic [7:0] CHAR_UQ    = 8'h51;
   localparam logic [7:0] CHAR_US    = 8'h53;
   localparam logic [7:0] CHAR_BAR   = 8'h7c;

   // Alignment records must be longer than this, terminator included
   localparam int unsigned MIN_RECORD_BYTES = 20;
   localparam int unsigned REC_LEN_W        = 5;
   localparam int unsigned PREFIX_TEXT_W    = 48;
   localparam int unsigned PREFIX_LENGTH_W  = 3;

   typedef enum logic {
      CSR_PREFIX_TEXT   = 1'b0,
      CSR_PREFIX_LENGTH = 1'b1
   } srpf_csr_index_type;

   // Per-byte verdict from the parser to the output stage
   typedef struct packed {
      logic byte_kept;
      logic record_end;
      logic record_keep;
   } srpf_result_type;

endpackage

[src/srpf_parser.sv]
module srpf_parser import srpf_pkg::*; #(
   parameter int MAX_PREFIX_BYTES = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [7:0]                 in_byte,
   input  logic [PREFIX_TEXT_W-1:0]   prefix_text,
   input  logic [PREFIX_LENGTH_W-1:0] prefix_length,
   output srpf_result_type            result
);

   localparam int MP_W = $clog2(MAX_PREFIX_BYTES + 2);
   localparam logic [MP_W-1:0] MAX_PLEN = MP_W'(MAX_PREFIX_BYTES);
   localparam logic [REC_LEN_W-1:0] LEN_SAT = REC_LEN_W'(MIN_RECORD_BYTES + 1);
   localparam logic [REC_LEN_W-1:0] LEN_MIN = REC_LEN_W'(MIN_RECORD_BYTES);

   typedef enum logic [13:0] {
      PH_START     = 14'h0001,
      PH_ALN_TABS  = 14'h0002,
      PH_ALN_MATCH = 14'h0004,
      PH_ALN_REST  = 14'h0008,
      PH_HDR_S     = 14'h0010,
      PH_HDR_Q     = 14'h0020,
      PH_HDR_PLAIN = 14'h0040,
      PH_SQ_TAG    = 14'h0080,
      PH_SQ_VALWS  = 14'h0100,
      PH_SQ_VAL    = 14'h0200,
      PH_SQ_SNM    = 14'h0400,
      PH_SQ_NUMWS  = 14'h0800,
      PH_SQ_NUMDIG = 14'h1000,
      PH_SQ_DONE   = 14'h2000
   } phase_type;

   function automatic logic [7:0] fold(input logic [7:0] c);
      fold = (c >= CHAR_UA && c <= CHAR_UZ) ? c + 8'd32 : c;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      is_blank = c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_NL ||
                 c == CHAR_VT || c == CHAR_FF || c == CHAR_CR;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = c >= CHAR_0 && c <= CHAR_9;
   endfunction

   // Tag letters of AS:, SN:, LN: in order
   function automatic logic [7:0] tag_char(input logic [1:0] t, input logic [1:0] p);
      logic [7:0] c;
      c = CHAR_COLON;
      if (p == 2'd0) begin
         if (t == 2'd0) c = CHAR_UA;
         else if (t == 2'd1) c = CHAR_US;
         else c = CHAR_UL;
      end else if (p == 2'd1) begin
         c = (t == 2'd0) ? CHAR_US : CHAR_UN;
      end
      tag_char = c;
   endfunction

   phase_type            phase_ff, phase_in;
   logic [1:0]           tab_ff, tab_in;
   logic [MP_W-1:0]      mp_ff, mp_in;
   logic [REC_LEN_W-1:0] rlen_ff, rlen_in;
   logic                 mismatch_ff, mismatch_in;
   logic                 parsed_ff, parsed_in;
   logic                 strip_ff, strip_in;

   logic [MP_W-1:0] plen;
   logic [MP_W-1:0] mp_inc;
   logic [3:0]      pos;
   logic [63:0]     prefix_ext;
   logic [7:0]      expected;
   logic            hit;
   logic            past_bar;
   logic            rec_long;

   always_comb begin
      if (prefix_length == '0) begin
         plen = MP_W'(1);
      end else if (4'(prefix_length) > 4'(MAX_PREFIX_BYTES)) begin
         plen = MAX_PLEN;
      end else begin
         plen = MP_W'(prefix_length);
      end
   end

   assign prefix_ext = {16'b0, prefix_text};
   assign pos        = 4'(mp_ff);
   assign expected   = (mp_ff < plen) ? prefix_ext[{pos[2:0], 3'b000} +: 8] : CHAR_BAR;
   assign hit        = expected != CHAR_NUL && fold(in_byte) == fold(expected);
   assign mp_inc     = mp_ff + MP_W'(1);
   assign past_bar   = mp_inc > plen;
   assign rlen_in    = (rlen_ff < LEN_SAT) ? rlen_ff + REC_LEN_W'(1) : rlen_ff;
   assign rec_long   = rlen_in > LEN_MIN;

   always_comb begin
      phase_in    = phase_ff;
      tab_in      = tab_ff;
      mp_in       = mp_ff;
      mismatch_in = mismatch_ff;
      parsed_in   = parsed_ff;
      strip_in    = strip_ff;
      result      = '{byte_kept: 1'b1, record_end: 1'b0, record_keep: 1'b0};

      if (in_byte == CHAR_NUL || in_byte == CHAR_NL) begin
         result.record_end = 1'b1;
         unique case (phase_ff)
            PH_START:
               result.record_keep = 1'b0;
            PH_ALN_TABS, PH_ALN_MATCH:
               result.record_keep = 1'b0;
            PH_ALN_REST:
               result.record_keep = rec_long && !mismatch_ff;
            PH_HDR_S, PH_HDR_Q, PH_HDR_PLAIN:
               result.record_keep = 1'b1;
            default:
               result.record_keep = parsed_ff ? !mismatch_ff : !strip_ff;
         endcase
         phase_in    = PH_START;
         tab_in      = '0;
         mp_in       = '0;
         mismatch_in = 1'b0;
         parsed_in   = 1'b0;
         strip_in    = 1'b0;
      end else begin
         unique case (phase_ff)
            PH_START: begin
               if (in_byte == CHAR_AT) begin
                  phase_in = PH_HDR_S;
               end else begin
                  tab_in   = (in_byte == CHAR_TAB) ? 2'd1 : 2'd0;
                  phase_in = PH_ALN_TABS;
               end
            end
            PH_ALN_TABS: begin
               if (in_byte == CHAR_TAB) begin
                  if (tab_ff >= 2'd1) begin
                     tab_in   = 2'd2;
                     mp_in    = '0;
                     phase_in = PH_ALN_MATCH;
                  end else begin
                     tab_in = tab_ff + 2'd1;
                  end
               end
            end
            PH_ALN_MATCH: begin
               if (hit) begin
                  mp_in            = mp_inc;
                  result.byte_kept = 1'b0;
                  if (past_bar) phase_in = PH_ALN_REST;
               end else begin
                  mismatch_in = 1'b1;
                  phase_in    = PH_ALN_REST;
               end
            end
            PH_HDR_S:
               phase_in = (in_byte == CHAR_US) ? PH_HDR_Q : PH_HDR_PLAIN;
            PH_HDR_Q: begin
               if (in_byte == CHAR_UQ) begin
                  tab_in   = '0;
                  mp_in    = '0;
                  phase_in = PH_SQ_TAG;
               end else begin
                  phase_in = PH_HDR_PLAIN;
               end
            end
            PH_SQ_TAG: begin
               if (mp_ff == '0 && is_blank(in_byte)) begin
                  phase_in = PH_SQ_TAG;
               end else if (tab_ff < 2'd3 && mp_ff < MP_W'(3) &&
                            in_byte == tag_char(tab_ff, 2'(mp_ff))) begin
                  if (mp_inc == MP_W'(3)) begin
                     mp_in    = '0;
                     phase_in = (tab_ff == 2'd2) ? PH_SQ_NUMWS : PH_SQ_VALWS;
                  end else begin
                     mp_in = mp_inc;
                  end
               end else begin
                  phase_in = PH_SQ_DONE;
               end
            end
            PH_SQ_VALWS, PH_SQ_SNM: begin
               if (is_blank(in_byte)) begin
                  if (phase_ff == PH_SQ_SNM) begin
                     mismatch_in = 1'b1;
                     tab_in      = 2'd2;
                     mp_in       = '0;
                     phase_in    = PH_SQ_TAG;
                  end
               end else if (phase_ff == PH_SQ_VALWS && tab_ff == 2'd0) begin
                  phase_in = PH_SQ_VAL;
               end else if (hit) begin
                  // SN value: strip matching prefix bytes as they arrive
                  mp_in            = mp_inc;
                  result.byte_kept = 1'b0;
                  strip_in         = 1'b1;
                  phase_in         = past_bar ? PH_SQ_VAL : PH_SQ_SNM;
               end else begin
                  mismatch_in = 1'b1;
                  phase_in    = PH_SQ_VAL;
               end
            end
            PH_SQ_VAL: begin
               if (is_blank(in_byte)) begin
                  tab_in   = tab_ff + 2'd1;
                  mp_in    = '0;
                  phase_in = (tab_ff < 2'd2) ? PH_SQ_TAG : PH_SQ_DONE;
               end
            end
            PH_SQ_NUMWS: begin
               if (!is_blank(in_byte)) begin
                  if (in_byte == CHAR_PLUS || in_byte == CHAR_MINUS) begin
                     phase_in = PH_SQ_NUMDIG;
                  end else begin
                     if (is_digit(in_byte)) parsed_in = 1'b1;
                     phase_in = PH_SQ_DONE;
                  end
               end
            end
            PH_SQ_NUMDIG: begin
               if (is_digit(in_byte)) parsed_in = 1'b1;
               phase_in = PH_SQ_DONE;
            end
            default:
               phase_in = phase_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         tab_ff      <= '0;
         mp_ff       <= '0;
         rlen_ff     <= '0;
         mismatch_ff <= 1'b0;
         parsed_ff   <= 1'b0;
         strip_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         tab_ff      <= tab_in;
         mp_ff       <= mp_in;
         rlen_ff     <= result.record_end ? '0 : rlen_in;
         mismatch_ff <= mismatch_in;
         parsed_ff   <= parsed_in;
         strip_ff    <= strip_in;
      end
   end

   // A terminator always returns the parser to the start of a record
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      advance && result.record_end |=> phase_ff == PH_START && rlen_ff == '0)
      else $error("parser state not cleared after record end");

   // Match position never runs past the prefix plus bar
   a_mp_bound: assert property (@(posedge clock) disable iff (reset)
      mp_ff <= MAX_PLEN + MP_W'(1))
      else $error("match position out of range");

   // Stripped bytes only occur while comparing a prefix
   a_strip_phase: assert property (@(posedge clock) disable iff (reset)
      !result.byte_kept |->
         phase_ff == PH_ALN_MATCH || phase_ff == PH_SQ_VALWS || phase_ff == PH_SQ_SNM)
      else $error("byte stripped outside a prefix compare");

endmodule

[src/sam_record_prefix_filter_core.sv]
// SAM record prefix filter. Takes a SAM text stream one byte per transaction
// on the req_ channel and returns one rsp_ transaction per byte: the byte
// itself, a flag saying whether it stays in the output (stripped prefix and
// bar bytes carry 0), and on the record terminator (newline or NUL, marked
// with tlast) a verdict to commit or discard the whole record in a
// downstream commit buffer. Alignment records are kept only when longer than
// 20 bytes and their third field begins with the prefix plus a bar, matched
// without regard to case. @SQ headers whose AS, SN and LN tags parse are
// dropped when SN lacks the prefix, otherwise SN loses it; unparsed @SQ
// headers drop if SN was stripped; others pass. The user must set the
// prefix through the csr_ port only while the stream is idle; the block
// does not enforce this. Index 0 writes prefix_text (first byte in the
// low bits), index 1 writes prefix_length. Throughput is one byte per cycle
// unless rsp_ stalls; each response sits in the single output register
// with the parser's verdict, and while stalled holds req_ until taken.
module sam_record_prefix_filter_core import srpf_pkg::*; #(
   parameter int MAX_PREFIX_BYTES = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   // request stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] in_byte
   // response stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,   // [7:0] out_byte
   output logic                      rsp_tlast,   // record_end
   output logic [1:0]                rsp_tuser,   // [0] byte_kept, [1] record_keep
   // register write channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_index,
   input  logic [PREFIX_TEXT_W-1:0]  csr_wdata
);

   logic [PREFIX_TEXT_W-1:0]   prefix_text_ff;
   logic [PREFIX_LENGTH_W-1:0] prefix_length_ff;

   logic            rsp_valid_ff;
   logic [7:0]      rsp_byte_ff;
   srpf_result_type rsp_result_ff;
   srpf_result_type result;
   logic            req_fire;

   // Take a new byte whenever the output register is empty or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_text_ff   <= '0;
         prefix_length_ff <= PREFIX_LENGTH_W'(1);
      end else if (csr_valid) begin
         unique case (srpf_csr_index_type'(csr_index))
            CSR_PREFIX_TEXT:   prefix_text_ff   <= csr_wdata;
            CSR_PREFIX_LENGTH: prefix_length_ff <= csr_wdata[PREFIX_LENGTH_W-1:0];
         endcase
      end
   end

   srpf_parser #(
      .MAX_PREFIX_BYTES (MAX_PREFIX_BYTES)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .advance       (req_fire),
      .in_byte       (req_tdata),
      .prefix_text   (prefix_text_ff),
      .prefix_length (prefix_length_ff),
      .result        (result)
   );

   // Output register: valid under reset, payload loads on every accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_byte_ff   <= req_tdata;
         rsp_result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_result_ff.record_end;
   assign rsp_tuser  = {rsp_result_ff.record_keep, rsp_result_ff.byte_kept};

   // An accepted byte always shows up in the output register next cycle
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_tvalid)
      else $error("accepted byte did not reach the output register");

   // The verdict is only given on a terminator
   a_keep_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !rsp_tuser[1])
      else $error("record verdict without record end");

   // Record end marks exactly newline and NUL bytes
   a_end_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == (rsp_tdata == CHAR_NL || rsp_tdata == CHAR_NUL))
      else $error("record end does not match terminator byte");

   // A terminator is never stripped
   a_end_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0])
      else $error("terminator marked as stripped");

endmodule

[tb/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import srpf_pkg::*;

   // Lower-case bounds for case folding; the package only names the upper ones
   localparam logic [7:0] CHAR_LA = 8'h61;
   localparam logic [7:0] CHAR_LZ = 8'h7a;

   localparam int RANDOM_BYTES  = 900;
   localparam int SEGMENTS      = 6;
   localparam int QUIET_LIMIT   = 4000;  // cycles without any transaction
   localparam int LONG_STALL    = 150;   // receiver hold-off, cycles
   localparam int MAX_REPORTS   = 40;
   localparam int SETTLE_CYCLES = 8;     // margin after the registered output

   // Parse position within the current record, mirrored from the block
   typedef enum logic [3:0] {
      SCAN_REC_START,
      SCAN_SEEK_FIELD3,
      SCAN_FIELD3_PREFIX,
      SCAN_ALN_BODY,
      SCAN_HDR_S,
      SCAN_HDR_Q,
      SCAN_HDR_OTHER,
      SCAN_SQ_TAG,
      SCAN_SQ_VALUE_WS,
      SCAN_SQ_VALUE,
      SCAN_SQ_SN_PREFIX,
      SCAN_SQ_LEN_WS,
      SCAN_SQ_LEN_DIGIT,
      SCAN_SQ_TAIL
   } scan_state_type;

   typedef struct packed {
      logic [7:0] data;
      logic       kept;
      logic       last;
      logic       commit;
   } byte_verdict_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [7:0]               req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [7:0]               rsp_tdata;
   logic                     rsp_tlast;
   logic [1:0]               rsp_tuser;
   logic                     csr_valid;
   logic                     csr_ready;
   srpf_csr_index_type       csr_index;
   logic [PREFIX_TEXT_W-1:0] csr_wdata;

   sam_record_prefix_filter_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Stream bytes waiting for the driver, and verdicts waiting for the block
   logic [7:0]       text_to_send[$];
   byte_verdict_type verdicts_due[$];

   // Shadow of the prefix registers, updated on each accepted write
   logic [PREFIX_TEXT_W-1:0]   cfg_text;
   logic [PREFIX_LENGTH_W-1:0] cfg_len;

   // Shadow parse state
   scan_state_type scan_state;
   int             scan_tabs;
   int             scan_pos;
   int             scan_len;
   bit             scan_miss;
   bit             scan_parsed;
   bit             scan_marked;

   // Idle control
   int tx_idle_pct;
   int rx_idle_pct;
   bit sender_hold;
   int stall_request;
   int stall_left;
   bit req_accepted;

   // Bookkeeping
   int  mismatches;
   int  bytes_queued;
   int  bytes_sent;
   int  responses;
   int  records_seen;
   int  records_committed;
   int  csr_writes;
   int  quiet_cycles;
   byte_verdict_type got_verdict;
   byte_verdict_type want_verdict;
   string alnum_set = "abcdefghijklmnopqrstuvwxyz0123456789";

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Byte-level predictor of the filter
   // ---------------------------------------------------------------------------

   function automatic logic [7:0] to_lower(logic [7:0] c);
      return (c >= CHAR_UA && c <= CHAR_UZ) ? c + 8'd32 : c;
   endfunction

   function automatic bit is_space(logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_NL ||
             c == CHAR_VT || c == CHAR_FF || c == CHAR_CR;
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= CHAR_0 && c <= CHAR_9;
   endfunction

   // Length 0 behaves as 1, anything past six as six
   function automatic int prefix_bytes();
      int n;
      n = int'(cfg_len);
      if (n == 0) n = 1;
      if (n > 6) n = 6;
      return n;
   endfunction

   // Prefix byte at pos, or the bar once the prefix is used up
   function automatic logic [7:0] prefix_char(int pos, int n);
      if (pos < n) return cfg_text[8*pos +: 8];
      return CHAR_BAR;
   endfunction

   // Letters of AS:, SN:, LN: by tag number and position
   function automatic logic [7:0] tag_letter(int tag, int pos);
      if (pos == 0) return (tag == 0) ? CHAR_UA : ((tag == 1) ? CHAR_US : CHAR_UL);
      if (pos == 1) return (tag == 0) ? CHAR_US : CHAR_UN;
      return CHAR_COLON;
   endfunction

   function automatic void restart_record();
      scan_state  = SCAN_REC_START;
      scan_tabs   = 0;
      scan_pos    = 0;
      scan_len    = 0;
      scan_miss   = 1'b0;
      scan_parsed = 1'b0;
      scan_marked = 1'b0;
   endfunction

   // Compare against the next prefix byte; a zero prefix byte never matches
   function automatic bit prefix_hit(logic [7:0] b, int n);
      logic [7:0] e;
      e = prefix_char(scan_pos, n);
      if (e != CHAR_NUL && to_lower(b) == to_lower(e)) begin
         scan_pos++;
         return 1'b1;
      end
      scan_miss = 1'b1;
      return 1'b0;
   endfunction

   // One byte of the SN value while the prefix may still match; returns kept
   function automatic logic sn_prefix_step(logic [7:0] b, int n);
      if (prefix_hit(b, n)) begin
         scan_marked = 1'b1;
         scan_state  = (scan_pos > n) ? SCAN_SQ_VALUE : SCAN_SQ_SN_PREFIX;
         return 1'b0;
      end
      scan_state = SCAN_SQ_VALUE;
      return 1'b1;
   endfunction

   function automatic byte_verdict_type predict_filter(logic [7:0] b);
      byte_verdict_type v;
      int n;
      n = prefix_bytes();
      v.data   = b;
      v.kept   = 1'b1;
      v.last   = 1'b0;
      v.commit = 1'b0;
      if (scan_len < 21) scan_len++;
      if (b == CHAR_NUL || b == CHAR_NL) begin
         v.last = 1'b1;
         case (scan_state)
            SCAN_REC_START, SCAN_SEEK_FIELD3, SCAN_FIELD3_PREFIX: v.commit = 1'b0;
            SCAN_ALN_BODY: v.commit = (scan_len > MIN_RECORD_BYTES) && !scan_miss;
            SCAN_HDR_S, SCAN_HDR_Q, SCAN_HDR_OTHER: v.commit = 1'b1;
            default: v.commit = scan_parsed ? !scan_miss : !scan_marked;
         endcase
         restart_record();
      end else begin
         case (scan_state)
            SCAN_REC_START: begin
               if (b == CHAR_AT) begin
                  scan_state = SCAN_HDR_S;
               end else begin
                  scan_tabs  = (b == CHAR_TAB) ? 1 : 0;
                  scan_state = SCAN_SEEK_FIELD3;
               end
            end
            SCAN_SEEK_FIELD3: begin
               if (b == CHAR_TAB) begin
                  scan_tabs++;
                  if (scan_tabs >= 2) begin
                     scan_tabs  = 2;
                     scan_pos   = 0;
                     scan_state = SCAN_FIELD3_PREFIX;
                  end
               end
            end
            SCAN_FIELD3_PREFIX: begin
               if (prefix_hit(b, n)) begin
                  v.kept = 1'b0;
                  if (scan_pos > n) scan_state = SCAN_ALN_BODY;
               end else begin
                  scan_state = SCAN_ALN_BODY;
               end
            end
            SCAN_HDR_S: scan_state = (b == CHAR_US) ? SCAN_HDR_Q : SCAN_HDR_OTHER;
            SCAN_HDR_Q: begin
               if (b == CHAR_UQ) begin
                  scan_tabs  = 0;
                  scan_pos   = 0;
                  scan_state = SCAN_SQ_TAG;
               end else begin
                  scan_state = SCAN_HDR_OTHER;
               end
            end
            SCAN_SQ_TAG: begin
               // Blanks before a tag are skipped; tag letters are case-sensitive
               if (!(scan_pos == 0 && is_space(b))) begin
                  if (scan_tabs < 3 && scan_pos < 3 && b == tag_letter(scan_tabs, scan_pos)) begin
                     scan_pos++;
                     if (scan_pos == 3) begin
                        scan_pos   = 0;
                        scan_state = (scan_tabs == 2) ? SCAN_SQ_LEN_WS : SCAN_SQ_VALUE_WS;
                     end
                  end else begin
                     scan_state = SCAN_SQ_TAIL;
                  end
               end
            end
            SCAN_SQ_VALUE_WS: begin
               if (!is_space(b)) begin
                  if (scan_tabs == 0) scan_state = SCAN_SQ_VALUE;
                  else v.kept = sn_prefix_step(b, n);
               end
            end
            SCAN_SQ_VALUE: begin
               if (is_space(b)) begin
                  scan_tabs++;
                  scan_pos   = 0;
                  scan_state = (scan_tabs <= 2) ? SCAN_SQ_TAG : SCAN_SQ_TAIL;
               end
            end
            SCAN_SQ_SN_PREFIX: begin
               // SN ended before prefix and bar were seen in full
               if (is_space(b)) begin
                  scan_miss  = 1'b1;
                  scan_tabs  = 2;
                  scan_pos   = 0;
                  scan_state = SCAN_SQ_TAG;
               end else begin
                  v.kept = sn_prefix_step(b, n);
               end
            end
            SCAN_SQ_LEN_WS: begin
               if (!is_space(b)) begin
                  if (b == CHAR_PLUS || b == CHAR_MINUS) begin
                     scan_state = SCAN_SQ_LEN_DIGIT;
                  end else begin
                     if (is_digit(b)) scan_parsed = 1'b1;
                     scan_state = SCAN_SQ_TAIL;
                  end
               end
            end
            SCAN_SQ_LEN_DIGIT: begin
               if (is_digit(b)) scan_parsed = 1'b1;
               scan_state = SCAN_SQ_TAIL;
            end
            default: ;
         endcase
      end
      return v;
   endfunction

   // ---------------------------------------------------------------------------
   // Stream text generation
   // ---------------------------------------------------------------------------

   function automatic void push_byte(logic [7:0] c);
      text_to_send.push_back(c);
      bytes_queued++;
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endfunction

   function automatic logic [7:0] vary_case(logic [7:0] c);
      if (c >= CHAR_LA && c <= CHAR_LZ && $urandom_range(1) == 1) return c - 8'd32;
      if (c >= CHAR_UA && c <= CHAR_UZ && $urandom_range(1) == 1) return c + 8'd32;
      return c;
   endfunction

   function automatic logic [7:0] alnum_char();
      return alnum_set[$urandom_range(alnum_set.len() - 1)];
   endfunction

   function automatic void push_word(int lo, int hi);
      int cnt;
      cnt = $urandom_range(lo, hi);
      for (int i = 0; i < cnt; i++) push_byte(vary_case(alnum_char()));
   endfunction

   function automatic void push_digits();
      int cnt;
      cnt = $urandom_range(1, 9);
      for (int i = 0; i < cnt; i++) push_byte(CHAR_0 + 8'($urandom_range(9)));
   endfunction

   // Field separators: mostly tabs and spaces, now and then VT, FF or CR
   function automatic void push_blanks(int lo);
      int cnt;
      cnt = $urandom_range(lo, 2);
      for (int i = 0; i < cnt; i++) begin
         case ($urandom_range(5))
            0, 1:    push_byte(CHAR_SPACE);
            2, 3:    push_byte(CHAR_TAB);
            4:       push_byte(CHAR_VT);
            default: push_byte($urandom_range(1) ? CHAR_FF : CHAR_CR);
         endcase
      end
   endfunction

   // First cnt prefix bytes in random case; flip one bit at bad_at to corrupt
   function automatic void push_prefix(int cnt, int bad_at);
      logic [7:0] c;
      for (int i = 0; i < cnt; i++) begin
         c = cfg_text[8*i +: 8];
         if (i == bad_at) c = c ^ 8'h01;
         push_byte(vary_case(c));
      end
   endfunction

   function automatic void push_record_end();
      if ($urandom_range(6) == 0) push_byte(CHAR_NUL);
      else push_byte(CHAR_NL);
   endfunction

   function automatic void gen_alignment();
      int n;
      int start;
      int target;
      int kind;
      n     = prefix_bytes();
      start = bytes_queued;
      kind  = $urandom_range(11);
      // An empty read name makes the record open with a tab
      if ($urandom_range(7) != 0) push_word(1, 10);
      push_byte(CHAR_TAB);
      push_digits();
      push_byte(CHAR_TAB);
      if (kind <= 6) begin
         push_prefix(n, -1);
         push_byte(CHAR_BAR);
         push_word(1, 6);
      end else if (kind == 7) begin
         push_prefix(n, -1);
         push_word(1, 6);
      end else if (kind == 8) begin
         push_prefix(n, $urandom_range(n - 1));
         push_byte(CHAR_BAR);
      end else if (kind == 10) begin
         push_prefix($urandom_range(1, n), -1);
      end else if (kind == 11) begin
         push_byte(CHAR_BAR);
      end
      // Lengths straddle the 20-byte floor
      target = $urandom_range(14, 40);
      while (bytes_queued - start < target - 1) begin
         if ($urandom_range(5) == 0) push_byte(CHAR_TAB);
         else push_byte(8'($urandom_range(33, 126)));
      end
      push_record_end();
   endfunction

   function automatic void gen_sq_header();
      int n;
      int sn_kind;
      int fault;
      n       = prefix_bytes();
      sn_kind = $urandom_range(9);
      fault   = $urandom_range(11);
      push_text("@SQ");
      push_blanks(fault == 0 ? 0 : 1);
      push_text(fault == 1 ? "As:" : "AS:");
      push_word(1, 6);
      push_blanks(1);
      push_text("SN:");
      if (sn_kind <= 4) begin
         push_prefix(n, -1);
         push_byte(CHAR_BAR);
         push_word(1, 6);
      end else if (sn_kind == 7) begin
         push_prefix(n, $urandom_range(n - 1));
         push_byte(CHAR_BAR);
         push_word(1, 6);
      end else if (sn_kind >= 8) begin
         // SN stops inside the prefix or before the bar
         push_prefix($urandom_range(1, n), -1);
      end else begin
         push_word(1, 6);
      end
      push_blanks(1);
      case (fault)
         2: push_text("LX:1");
         3: push_text("LN:+42");
         4: push_text("LN:-");
         5: push_text("LN:x9");
         6: ;
         default: begin
            push_text("LN:");
            push_digits();
         end
      endcase
      if ($urandom_range(2) == 0) begin
         push_byte(CHAR_TAB);
         push_text("M5:");
         push_word(1, 8);
      end
      push_record_end();
   endfunction

   function automatic void gen_other_header();
      case ($urandom_range(7))
         0: push_text("@HD\tVN:1.6\tSO:coordinate");
         1: begin
            push_text("@RG\tID:");
            push_word(1, 8);
         end
         2: push_text("@S");
         3: push_text("@SA\tx");
         4: push_text("@");
         5: push_text("@SQ");
         6: push_text("@Sq\tAS:x\tSN:y\tLN:1");
         default: begin
            push_text("@CO\t");
            push_word(1, 12);
         end
      endcase
      push_record_end();
   endfunction

   function automatic void gen_noise();
      int cnt;
      cnt = $urandom_range(0, 20);
      for (int i = 0; i < cnt; i++) push_byte(8'($urandom_range(255)));
      push_record_end();
   endfunction

   function automatic void gen_record();
      int pick;
      pick = $urandom_range(99);
      if (pick < 42) gen_alignment();
      else if (pick < 72) gen_sq_header();
      else if (pick < 86) gen_other_header();
      else gen_noise();
   endfunction

   function automatic logic [PREFIX_TEXT_W-1:0] random_prefix_text(bit mixed_case);
      logic [PREFIX_TEXT_W-1:0] t;
      for (int i = 0; i < 6; i++) t[8*i +: 8] = mixed_case ? vary_case(alnum_char()) : alnum_char();
      return t;
   endfunction

   // ---------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%0t ns mismatch: %0s", $realtime, msg);
   endtask

   // Driver: present the next byte at the falling edge; hold it until taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_accepted) begin
         if (text_to_send.size() > 0 && !sender_hold &&
             $urandom_range(99) >= tx_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= text_to_send.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random backpressure, plus one long hold-off when requested
   always @(negedge clock) begin
      if (stall_request > 0) begin
         stall_left    = stall_request;
         stall_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Monitor: check each response transaction, then predict each request
   always @(posedge clock) begin
      if (reset) begin
         req_accepted = 1'b0;
      end else begin
         req_accepted = req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got_verdict.data   = rsp_tdata;
            got_verdict.kept   = rsp_tuser[0];
            got_verdict.last   = rsp_tlast;
            got_verdict.commit = rsp_tuser[1];
            responses++;
            if (rsp_tlast) begin
               records_seen++;
               if (rsp_tuser[1]) records_committed++;
            end
            if (verdicts_due.size() == 0) begin
               report_mismatch($sformatf("response %0d with nothing outstanding", responses));
            end else begin
               want_verdict = verdicts_due.pop_front();
               if (got_verdict.data !== want_verdict.data)
                  report_mismatch($sformatf("response %0d out_byte %h, expected %h",
                                            responses, got_verdict.data, want_verdict.data));
               if (got_verdict.kept !== want_verdict.kept)
                  report_mismatch($sformatf("response %0d byte_kept %b, expected %b",
                                            responses, got_verdict.kept, want_verdict.kept));
               if (got_verdict.last !== want_verdict.last)
                  report_mismatch($sformatf("response %0d record_end %b, expected %b",
                                            responses, got_verdict.last, want_verdict.last));
               if (got_verdict.commit !== want_verdict.commit)
                  report_mismatch($sformatf("response %0d record_keep %b, expected %b",
                                            responses, got_verdict.commit, want_verdict.commit));
            end
         end
         if (req_accepted) begin
            verdicts_due.push_back(predict_filter(req_tdata));
            bytes_sent++;
         end
      end
   end

   // Watchdog: give up after a long stretch with no transaction on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: %0d cycles without a transaction", quiet_cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequencing
   // ---------------------------------------------------------------------------

   task automatic write_csr(input srpf_csr_index_type idx, input logic [PREFIX_TEXT_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_PREFIX_TEXT) cfg_text = val;
      else cfg_len = val[PREFIX_LENGTH_W-1:0];
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_prefix(input logic [PREFIX_TEXT_W-1:0] text, input int len);
      write_csr(CSR_PREFIX_TEXT, text);
      write_csr(CSR_PREFIX_LENGTH, PREFIX_TEXT_W'(len));
   endtask

   // Wait until every queued byte is sent and every verdict has come back
   task automatic drain();
      while (text_to_send.size() != 0 || req_tvalid || verdicts_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int seg_start;

      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = CSR_PREFIX_TEXT;
      csr_wdata     = '0;
      cfg_text      = '0;
      cfg_len       = 3'd1;
      tx_idle_pct   = 0;
      rx_idle_pct   = 0;
      sender_hold   = 1'b0;
      stall_request = 0;
      stall_left    = 0;
      req_accepted  = 1'b0;
      quiet_cycles  = 0;
      restart_record();

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed: an all-zero prefix with length 0 never matches
      set_prefix('0, 0);
      push_text("r0\t4\tchr1|aaaaaaaaaaaaaaaa\n");
      push_text("\n");
      // NUL ends a record; the next byte opens a new one
      push_text("@SQ\tAS:a");
      push_byte(CHAR_NUL);
      push_text("x\n");
      drain();

      // Prefix "abc"; bytes beyond the length are junk and must be ignored
      set_prefix(48'h7a7a7a_636261, 3);
      push_text("\t\tabc|xxxxxxxxxxxxx\n");                // 20 bytes: too short
      push_text("\t\tAbC|xxxxxxxxxxxxxx\n");               // 21 bytes: commit
      push_text("rd\t0\tab\n");                           // field ends inside prefix
      push_text("@SQ\tAS:g1\tSN:ABC|chr1\tLN:100\tM5:ff\n"); // strip SN prefix
      push_text("@SQ AS:g1 SN:chr2 LN:-5\n");             // parsed, no prefix: drop
      push_text("@SQ\tAS:g1\tSN:abc|chr3\tLN:x\n");       // marked but unparsed: drop
      push_text("@SQ\tas:g1\tSN:chr4\tLN:1\n");           // tag case differs: pass
      push_text("@SQ\tAS:g1\tSN:ab\tLN:7\n");             // SN stops short: drop
      push_text("@HD\tVN:1.6\n");
      push_byte(8'hff);
      push_byte(8'h80);
      push_byte(CHAR_NUL);
      drain();

      // Random segments: two per stall profile, each under its own prefix
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: set_prefix(random_prefix_text(1'b0), 0);
            1: set_prefix({PREFIX_TEXT_W{1'b1}}, 7);
            2: set_prefix(random_prefix_text(1'b0), $urandom_range(1, 6));
            3: set_prefix(random_prefix_text(1'b0), 6);
            4: set_prefix(random_prefix_text(1'b1), $urandom_range(1, 6));
            default: set_prefix(PREFIX_TEXT_W'({$urandom, $urandom}), $urandom_range(0, 7));
         endcase
         case (seg / 2)
            0: begin
               tx_idle_pct = 32;
               rx_idle_pct = 53;
            end
            1: begin
               tx_idle_pct = 53;
               rx_idle_pct = 32;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         seg_start = bytes_queued;
         while (bytes_queued - seg_start < RANDOM_BYTES / SEGMENTS) gen_record();

         // Stop offering halfway through until the block has answered everything
         if (seg == 2) begin
            while (text_to_send.size() > RANDOM_BYTES / (2 * SEGMENTS)) @(posedge clock);
            sender_hold = 1'b1;
            while (req_tvalid || verdicts_due.size() != 0) @(posedge clock);
            sender_hold = 1'b0;
         end

         // Back up the response side while the sender keeps pushing
         if (seg == 4) stall_request = LONG_STALL;

         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (verdicts_due.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", verdicts_due.size()));

      $display("summary: %0d stream bytes, %0d records (%0d committed), %0d register writes",
               bytes_sent, records_seen, records_committed, csr_writes);
      $display("summary: prefix lengths 0 through 7, three stall profiles, %0d mismatches",
               mismatches);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
